### rtl/msc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

    // fixed field widths
    localparam int VOXEL_W     = 16;
    localparam int DIM_X_W     = 11;
    localparam int DIM_YZ_W    = 7;
    localparam int POS_X_W     = 10;
    localparam int OUT_X_W     = 10;
    localparam int OUT_Y_W     = 6;
    localparam int OUT_Z_W     = 6;
    localparam int PLANE_LIMIT = 1024;

    // register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIM_Z = 2'd2;

    localparam int RESET_DIM_X = 20;
    localparam int RESET_DIM_Y = 10;
    localparam int RESET_DIM_Z = 8;

    // control of the item in the sum stage
    typedef struct packed {
        logic valid;
        logic last;
        logic z_ok;
        logic y_ok;
        logic x_ok;
    } t_s1_ctrl;

    // last position index on an axis: zero counts as one, large values saturate
    function automatic int unsigned f_dim_last(int unsigned dim, int unsigned limit);
        if (dim == 0) begin
            return 0;
        end else if (dim > limit) begin
            return limit - 1;
        end
        return dim - 1;
    endfunction

endpackage

`default_nettype wire

### rtl/msc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// voxel stream
interface msc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [msc_pkg::VOXEL_W-1:0]    voxel;
    logic                                  last_voxel;

    modport source (output valid, output voxel, output last_voxel, input ready);
    modport sink (input valid, input voxel, input last_voxel, output ready);
endinterface

// result stream
interface msc_out_if #(
    parameter int SUM_W = 21
);
    logic                               valid;
    logic                               ready;
    logic signed [SUM_W-1:0]            best_sum;
    logic [msc_pkg::OUT_X_W-1:0]        best_x;
    logic [msc_pkg::OUT_Y_W-1:0]        best_y;
    logic [msc_pkg::OUT_Z_W-1:0]        best_z;

    modport source (output valid, output best_sum, output best_x, output best_y,
                    output best_z, input ready);
    modport sink (input valid, input best_sum, input best_x, input best_y,
                  input best_z, output ready);
endinterface

`default_nettype wire

### rtl/max_sum_cube_window_search.sv
// result: a last voxel passes the sum-stage register, then the output or skid register
// throughput: one voxel per cycle, one store read and one write per cycle; input stalls
// while a second result waits, and while a last voxel meets an unread result
// reset: synchronous, active low; clears positions, best sum, handshake flags and the
// dimension registers (20, 10, 8); line and plane stores are not cleared
`timescale 1ns / 1ps
`default_nettype none

module max_sum_cube_window_search #(
    parameter int WINDOW      = 3,
    parameter int MAX_ROW_LEN = 64,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    msc_in_if.sink                                 i_in,
    msc_out_if.source                              o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [msc_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [msc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [msc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    localparam int TAIL  = WINDOW - 1;
    localparam int ZW    = $clog2(MAX_ROW_LEN);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int LW    = (TAIL > 1) ? $clog2(TAIL) : 1;
    localparam int RW    = msc_pkg::VOXEL_W + $clog2(WINDOW);
    localparam int PW    = msc_pkg::VOXEL_W + $clog2(WINDOW * WINDOW);
    localparam int SUM_W = msc_pkg::VOXEL_W + $clog2(WINDOW * WINDOW * WINDOW);

    logic                           w_restart;
    logic [msc_pkg::POS_X_W-1:0]    w_x_last;
    logic [YW-1:0]                  w_y_last;
    logic [ZW-1:0]                  w_z_last;
    logic                           w_in_ready;
    logic                           w_accept;
    logic [ZW-1:0]                  w_row_raddr;
    logic [YW+ZW-1:0]               w_plane_raddr;
    msc_pkg::t_s1_ctrl              w_s1;
    logic signed [RW-1:0]           w_rs;
    logic signed [PW-1:0]           w_ps;
    logic [ZW-1:0]                  w_wr_z;
    logic [YW-1:0]                  w_wr_y;
    logic [LW-1:0]                  w_ylane;
    logic [LW-1:0]                  w_xlane;
    logic [msc_pkg::OUT_X_W-1:0]    w_cx;
    logic [msc_pkg::OUT_Y_W-1:0]    w_cy;
    logic [msc_pkg::OUT_Z_W-1:0]    w_cz;
    logic [TAIL-1:0][RW-1:0]        w_row_sums;
    logic [TAIL-1:0][PW-1:0]        w_plane_sums;

    assign pready     = 1'b1;
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // dimension registers
    msc_cfg #(
        .MAX_ROW_LEN (MAX_ROW_LEN),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_restart (w_restart),
        .o_x_last  (w_x_last),
        .o_y_last  (w_y_last),
        .o_z_last  (w_z_last)
    );

    // position tracking, row tail and row sum
    msc_front #(
        .WINDOW      (WINDOW),
        .MAX_ROW_LEN (MAX_ROW_LEN),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_voxel       (i_in.voxel),
        .i_last        (i_in.last_voxel),
        .i_restart     (w_restart),
        .i_x_last      (w_x_last),
        .i_y_last      (w_y_last),
        .i_z_last      (w_z_last),
        .o_row_raddr   (w_row_raddr),
        .o_plane_raddr (w_plane_raddr),
        .o_s1          (w_s1),
        .o_rs          (w_rs),
        .o_wr_z        (w_wr_z),
        .o_wr_y        (w_wr_y),
        .o_ylane       (w_ylane),
        .o_xlane       (w_xlane),
        .o_cx          (w_cx),
        .o_cy          (w_cy),
        .o_cz          (w_cz)
    );

    // row sums of the previous rows, one lane per row slot
    msc_lane_ram #(
        .ADDR_W (ZW),
        .DATA_W (RW),
        .LANES  (TAIL)
    ) u_row_lines (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_row_raddr),
        .o_rd_data (w_row_sums),
        .i_wr_en   (w_s1.valid && w_s1.z_ok),
        .i_wr_addr (w_wr_z),
        .i_wr_lane (w_ylane),
        .i_wr_data (w_rs)
    );

    // square sums of the previous planes, one lane per plane slot
    msc_lane_ram #(
        .ADDR_W (YW + ZW),
        .DATA_W (PW),
        .LANES  (TAIL)
    ) u_plane_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_plane_raddr),
        .o_rd_data (w_plane_sums),
        .i_wr_en   (w_s1.valid && w_s1.z_ok && w_s1.y_ok),
        .i_wr_addr ({w_wr_y, w_wr_z}),
        .i_wr_lane (w_xlane),
        .i_wr_data (w_ps)
    );

    // cube sum, best tracking and result beat
    msc_best #(
        .WINDOW (WINDOW)
    ) u_best (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (w_restart),
        .i_s1         (w_s1),
        .i_rs         (w_rs),
        .i_row_sums   (w_row_sums),
        .i_plane_sums (w_plane_sums),
        .i_cx         (w_cx),
        .i_cy         (w_cy),
        .i_cz         (w_cz),
        .o_ps         (w_ps),
        .o_in_ready   (w_in_ready),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_best_sum   (o_out.best_sum),
        .o_best_x     (o_out.best_x),
        .o_best_y     (o_out.best_y),
        .o_best_z     (o_out.best_z)
    );

endmodule

`default_nettype wire

### rtl/msc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module msc_cfg #(
    parameter int MAX_ROW_LEN = 64,
    parameter int MAX_ROWS    = 64,
    localparam int ZW = $clog2(MAX_ROW_LEN),
    localparam int YW = $clog2(MAX_ROWS)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic [msc_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  wire logic [msc_pkg::APB_DATA_W-1:0]    i_pwdata,
    output logic      [msc_pkg::APB_DATA_W-1:0]    o_prdata,
    output logic                                   o_restart,
    output logic      [msc_pkg::POS_X_W-1:0]       o_x_last,
    output logic      [YW-1:0]                     o_y_last,
    output logic      [ZW-1:0]                     o_z_last
);

    logic [msc_pkg::DIM_X_W-1:0]   r_dim_x;
    logic [msc_pkg::DIM_YZ_W-1:0]  r_dim_y;
    logic [msc_pkg::DIM_YZ_W-1:0]  r_dim_z;
    logic [msc_pkg::POS_X_W-1:0]   r_x_last;
    logic [YW-1:0]                 r_y_last;
    logic [ZW-1:0]                 r_z_last;
    logic [msc_pkg::REG_IDX_W-1:0] w_idx;
    logic                          w_wr;
    logic [msc_pkg::DIM_X_W-1:0]   w_wdata_x;
    logic [msc_pkg::DIM_YZ_W-1:0]  w_wdata_yz;

    // word index, byte offset ignored
    assign w_idx      = i_paddr[msc_pkg::APB_ADDR_W-1:2];
    assign w_wr       = i_psel && i_penable && i_pwrite;
    assign w_wdata_x  = i_pwdata[msc_pkg::DIM_X_W-1:0];
    assign w_wdata_yz = i_pwdata[msc_pkg::DIM_YZ_W-1:0];

    // any write to a dimension restarts the volume
    assign o_restart = w_wr && (w_idx == msc_pkg::REG_DIM_X || w_idx == msc_pkg::REG_DIM_Y ||
                                w_idx == msc_pkg::REG_DIM_Z);

    // dimension registers and their clamped last indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x  <= msc_pkg::DIM_X_W'(msc_pkg::RESET_DIM_X);
            r_dim_y  <= msc_pkg::DIM_YZ_W'(msc_pkg::RESET_DIM_Y);
            r_dim_z  <= msc_pkg::DIM_YZ_W'(msc_pkg::RESET_DIM_Z);
            r_x_last <= msc_pkg::POS_X_W'(msc_pkg::f_dim_last(msc_pkg::RESET_DIM_X,
                                                               msc_pkg::PLANE_LIMIT));
            r_y_last <= YW'(msc_pkg::f_dim_last(msc_pkg::RESET_DIM_Y, MAX_ROWS));
            r_z_last <= ZW'(msc_pkg::f_dim_last(msc_pkg::RESET_DIM_Z, MAX_ROW_LEN));
        end else if (w_wr) begin
            case (w_idx)
                msc_pkg::REG_DIM_X: begin
                    r_dim_x  <= w_wdata_x;
                    r_x_last <= msc_pkg::POS_X_W'(msc_pkg::f_dim_last(32'(w_wdata_x),
                                                                       msc_pkg::PLANE_LIMIT));
                end
                msc_pkg::REG_DIM_Y: begin
                    r_dim_y  <= w_wdata_yz;
                    r_y_last <= YW'(msc_pkg::f_dim_last(32'(w_wdata_yz), MAX_ROWS));
                end
                msc_pkg::REG_DIM_Z: begin
                    r_dim_z  <= w_wdata_yz;
                    r_z_last <= ZW'(msc_pkg::f_dim_last(32'(w_wdata_yz), MAX_ROW_LEN));
                end
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            msc_pkg::REG_DIM_X: o_prdata = msc_pkg::APB_DATA_W'(r_dim_x);
            msc_pkg::REG_DIM_Y: o_prdata = msc_pkg::APB_DATA_W'(r_dim_y);
            msc_pkg::REG_DIM_Z: o_prdata = msc_pkg::APB_DATA_W'(r_dim_z);
            default:            o_prdata = '0;
        endcase
    end

    assign o_x_last = r_x_last;
    assign o_y_last = r_y_last;
    assign o_z_last = r_z_last;

endmodule

`default_nettype wire

### rtl/msc_lane_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module msc_lane_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 18,
    parameter int LANES  = 2,
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rd_en,
    input  wire logic [ADDR_W-1:0]             i_rd_addr,
    output logic      [LANES-1:0][DATA_W-1:0]  o_rd_data,
    input  wire logic                          i_wr_en,
    input  wire logic [ADDR_W-1:0]             i_wr_addr,
    input  wire logic [LANE_W-1:0]             i_wr_lane,
    input  wire logic [DATA_W-1:0]             i_wr_data
);

    logic [LANES-1:0][DATA_W-1:0] r_mem [1 << ADDR_W];
    logic [LANES-1:0][DATA_W-1:0] r_rd_data;

    // one word holds all lanes, a write touches one lane
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][i_wr_lane] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/msc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module msc_front #(
    parameter int WINDOW      = 3,
    parameter int MAX_ROW_LEN = 64,
    parameter int MAX_ROWS    = 64,
    localparam int TAIL = WINDOW - 1,
    localparam int ZW   = $clog2(MAX_ROW_LEN),
    localparam int YW   = $clog2(MAX_ROWS),
    localparam int LW   = (TAIL > 1) ? $clog2(TAIL) : 1,
    localparam int RW   = msc_pkg::VOXEL_W + $clog2(WINDOW)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_accept,
    input  wire logic signed [msc_pkg::VOXEL_W-1:0]   i_voxel,
    input  wire logic                                 i_last,
    input  wire logic                                 i_restart,
    input  wire logic        [msc_pkg::POS_X_W-1:0]   i_x_last,
    input  wire logic        [YW-1:0]                 i_y_last,
    input  wire logic        [ZW-1:0]                 i_z_last,
    output logic             [ZW-1:0]                 o_row_raddr,
    output logic             [YW+ZW-1:0]              o_plane_raddr,
    output msc_pkg::t_s1_ctrl                         o_s1,
    output logic signed      [RW-1:0]                 o_rs,
    output logic             [ZW-1:0]                 o_wr_z,
    output logic             [YW-1:0]                 o_wr_y,
    output logic             [LW-1:0]                 o_ylane,
    output logic             [LW-1:0]                 o_xlane,
    output logic             [msc_pkg::OUT_X_W-1:0]   o_cx,
    output logic             [msc_pkg::OUT_Y_W-1:0]   o_cy,
    output logic             [msc_pkg::OUT_Z_W-1:0]   o_cz
);

    logic [msc_pkg::POS_X_W-1:0]          r_pos_x, n_pos_x;
    logic [YW-1:0]                        r_pos_y, n_pos_y;
    logic [ZW-1:0]                        r_pos_z, n_pos_z;
    logic [LW-1:0]                        r_ylane, n_ylane;
    logic [LW-1:0]                        r_xlane, n_xlane;
    logic signed [msc_pkg::VOXEL_W-1:0]   r_tail [TAIL];
    msc_pkg::t_s1_ctrl                    r_s1, n_s1;
    logic signed [RW-1:0]                 r_rs, n_rs;
    logic [ZW-1:0]                        r_wr_z;
    logic [YW-1:0]                        r_wr_y;
    logic [LW-1:0]                        r_ylane_s1;
    logic [LW-1:0]                        r_xlane_s1;
    logic [msc_pkg::OUT_X_W-1:0]          r_cx;
    logic [msc_pkg::OUT_Y_W-1:0]          r_cy;
    logic [msc_pkg::OUT_Z_W-1:0]          r_cz;

    // raster position and lane counters
    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        n_ylane = r_ylane;
        n_xlane = r_xlane;
        if (i_restart || (i_accept && i_last)) begin
            n_pos_x = '0;
            n_pos_y = '0;
            n_pos_z = '0;
            n_ylane = '0;
            n_xlane = '0;
        end else if (i_accept) begin
            if (r_pos_z == i_z_last) begin
                n_pos_z = '0;
                if (r_pos_y == i_y_last) begin
                    n_pos_y = '0;
                    n_ylane = '0;
                    if (r_pos_x == i_x_last) begin
                        n_pos_x = '0;
                        n_xlane = '0;
                    end else begin
                        n_pos_x = r_pos_x + 1'b1;
                        n_xlane = (r_xlane == LW'(TAIL - 1)) ? '0 : r_xlane + 1'b1;
                    end
                end else begin
                    n_pos_y = r_pos_y + 1'b1;
                    n_ylane = (r_ylane == LW'(TAIL - 1)) ? '0 : r_ylane + 1'b1;
                end
            end else begin
                n_pos_z = r_pos_z + 1'b1;
            end
        end
    end

    // row sum of the voxel and the row tail
    always_comb begin
        n_rs = RW'(i_voxel);
        for (int i = 0; i < TAIL; i++) begin
            n_rs = n_rs + RW'(r_tail[i]);
        end
    end

    // valid, last and window-full flags for the sum stage
    always_comb begin
        n_s1.valid = i_accept;
        n_s1.last  = i_last;
        n_s1.z_ok  = r_pos_z >= ZW'(TAIL);
        n_s1.y_ok  = r_pos_y >= YW'(TAIL);
        n_s1.x_ok  = r_pos_x >= msc_pkg::POS_X_W'(TAIL);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_ylane <= '0;
            r_xlane <= '0;
            r_s1    <= '0;
        end else begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
            r_ylane <= n_ylane;
            r_xlane <= n_xlane;
            r_s1    <= n_s1;
        end
    end

    // row tail shift and sum-stage payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tail[0] <= i_voxel;
            for (int i = 1; i < TAIL; i++) begin
                r_tail[i] <= r_tail[i-1];
            end
            r_rs       <= n_rs;
            r_wr_z     <= r_pos_z;
            r_wr_y     <= r_pos_y;
            r_ylane_s1 <= r_ylane;
            r_xlane_s1 <= r_xlane;
            r_cx       <= msc_pkg::OUT_X_W'(r_pos_x - msc_pkg::POS_X_W'(TAIL));
            r_cy       <= msc_pkg::OUT_Y_W'(r_pos_y - YW'(TAIL));
            r_cz       <= msc_pkg::OUT_Z_W'(r_pos_z - ZW'(TAIL));
        end
    end

    // line and plane stores are read at the position of the incoming voxel
    assign o_row_raddr   = r_pos_z;
    assign o_plane_raddr = {r_pos_y, r_pos_z};

    assign o_s1    = r_s1;
    assign o_rs    = r_rs;
    assign o_wr_z  = r_wr_z;
    assign o_wr_y  = r_wr_y;
    assign o_ylane = r_ylane_s1;
    assign o_xlane = r_xlane_s1;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_cz    = r_cz;

endmodule

`default_nettype wire

### rtl/msc_best.sv
`timescale 1ns / 1ps
`default_nettype none

module msc_best #(
    parameter int WINDOW = 3,
    localparam int TAIL = WINDOW - 1,
    localparam int RW   = msc_pkg::VOXEL_W + $clog2(WINDOW),
    localparam int PW   = msc_pkg::VOXEL_W + $clog2(WINDOW * WINDOW),
    localparam int CW   = msc_pkg::VOXEL_W + $clog2(WINDOW * WINDOW * WINDOW)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_restart,
    input  wire msc_pkg::t_s1_ctrl                    i_s1,
    input  wire logic signed [RW-1:0]                 i_rs,
    input  wire logic        [TAIL-1:0][RW-1:0]       i_row_sums,
    input  wire logic        [TAIL-1:0][PW-1:0]       i_plane_sums,
    input  wire logic        [msc_pkg::OUT_X_W-1:0]   i_cx,
    input  wire logic        [msc_pkg::OUT_Y_W-1:0]   i_cy,
    input  wire logic        [msc_pkg::OUT_Z_W-1:0]   i_cz,
    output logic signed      [PW-1:0]                 o_ps,
    output logic                                      o_in_ready,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output logic signed      [CW-1:0]                 o_best_sum,
    output logic             [msc_pkg::OUT_X_W-1:0]   o_best_x,
    output logic             [msc_pkg::OUT_Y_W-1:0]   o_best_y,
    output logic             [msc_pkg::OUT_Z_W-1:0]   o_best_z
);

    logic signed [PW-1:0]            n_ps;
    logic signed [CW-1:0]            n_cs;
    logic                            n_take;
    logic                            n_produce;
    logic signed [CW-1:0]            n_best_sum;
    logic [msc_pkg::OUT_X_W-1:0]     n_best_x;
    logic [msc_pkg::OUT_Y_W-1:0]     n_best_y;
    logic [msc_pkg::OUT_Z_W-1:0]     n_best_z;
    logic                            n_out_free;

    logic                            r_have;
    logic signed [CW-1:0]            r_best_sum;
    logic [msc_pkg::OUT_X_W-1:0]     r_best_x;
    logic [msc_pkg::OUT_Y_W-1:0]     r_best_y;
    logic [msc_pkg::OUT_Z_W-1:0]     r_best_z;

    logic                            r_out_valid;
    logic signed [CW-1:0]            r_out_sum;
    logic [msc_pkg::OUT_X_W-1:0]     r_out_x;
    logic [msc_pkg::OUT_Y_W-1:0]     r_out_y;
    logic [msc_pkg::OUT_Z_W-1:0]     r_out_z;

    logic                            r_skid_valid;
    logic signed [CW-1:0]            r_skid_sum;
    logic [msc_pkg::OUT_X_W-1:0]     r_skid_x;
    logic [msc_pkg::OUT_Y_W-1:0]     r_skid_y;
    logic [msc_pkg::OUT_Z_W-1:0]     r_skid_z;

    // square sum and cube sum from the stored lanes
    always_comb begin
        n_ps = PW'(i_rs);
        for (int i = 0; i < TAIL; i++) begin
            n_ps = n_ps + PW'($signed(i_row_sums[i]));
        end
        n_cs = CW'(n_ps);
        for (int i = 0; i < TAIL; i++) begin
            n_cs = n_cs + CW'($signed(i_plane_sums[i]));
        end
    end

    // strict greater test keeps the earliest corner on a tie
    always_comb begin
        n_take = i_s1.valid && i_s1.z_ok && i_s1.y_ok && i_s1.x_ok &&
                 (!r_have || (n_cs > r_best_sum));
        n_best_sum = n_take ? n_cs : r_best_sum;
        n_best_x   = n_take ? i_cx : r_best_x;
        n_best_y   = n_take ? i_cy : r_best_y;
        n_best_z   = n_take ? i_cz : r_best_z;
        n_produce  = i_s1.valid && i_s1.last;
        n_out_free = !r_out_valid || i_out_ready;
    end

    // running best, cleared at reset, end of volume or restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || n_produce) begin
            r_have     <= 1'b0;
            r_best_sum <= '0;
            r_best_x   <= '0;
            r_best_y   <= '0;
            r_best_z   <= '0;
        end else begin
            r_have     <= r_have || n_take;
            r_best_sum <= n_best_sum;
            r_best_x   <= n_best_x;
            r_best_y   <= n_best_y;
            r_best_z   <= n_best_z;
        end
    end

    // output beat valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (n_out_free) begin
            r_out_valid  <= r_skid_valid || n_produce;
            r_skid_valid <= r_skid_valid && n_produce;
        end else if (n_produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (n_out_free) begin
            if (r_skid_valid) begin
                r_out_sum <= r_skid_sum;
                r_out_x   <= r_skid_x;
                r_out_y   <= r_skid_y;
                r_out_z   <= r_skid_z;
                if (n_produce) begin
                    r_skid_sum <= n_best_sum;
                    r_skid_x   <= n_best_x;
                    r_skid_y   <= n_best_y;
                    r_skid_z   <= n_best_z;
                end
            end else if (n_produce) begin
                r_out_sum <= n_best_sum;
                r_out_x   <= n_best_x;
                r_out_y   <= n_best_y;
                r_out_z   <= n_best_z;
            end
        end else if (n_produce) begin
            r_skid_sum <= n_best_sum;
            r_skid_x   <= n_best_x;
            r_skid_y   <= n_best_y;
            r_skid_z   <= n_best_z;
        end
    end

    // hold input only when a second result could have nowhere to go
    assign o_in_ready = !r_skid_valid && !(i_s1.valid && i_s1.last && r_out_valid);

    assign o_ps        = n_ps;
    assign o_out_valid = r_out_valid;
    assign o_best_sum  = r_out_sum;
    assign o_best_x    = r_out_x;
    assign o_best_y    = r_out_y;
    assign o_best_z    = r_out_z;

endmodule

`default_nettype wire

### rtl/msc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module msc_checker #(
    parameter int SUM_W = 21
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    i_in_ready,
    input wire logic                    i_in_last,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [SUM_W-1:0] i_out_sum
);

    logic w_in_beat;

    assign w_in_beat = i_in_valid && i_in_ready;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sum))
        else $error("result beat dropped or changed while stalled");

    // a result shows up only after a last voxel has been accepted
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_beat && i_in_last, 2))
        else $error("result beat without a preceding last voxel");

    // empty output side never holds off the voxel stream
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with no result pending");

    // a second result behind a stalled one blocks further voxels
    a_ready_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_in_last && i_out_valid && !i_out_ready |=> !i_in_ready)
        else $error("input taken while two results are pending");

endmodule

bind max_sum_cube_window_search msc_checker #(
    .SUM_W (SUM_W)
) u_msc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_voxel),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_sum   (o_out.best_sum)
);

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 10;
    localparam int CUBE_TAIL     = 2;      // cube edge minus one
    localparam int ROW_LEN_MAX   = 64;
    localparam int ROWS_MAX      = 64;
    localparam int SUM_W         = 21;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;      // result follows the last beat through the sum and output registers
    localparam int CYCLE_LIMIT   = 1_000_000;

    // index past the defined registers
    localparam logic [msc_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {
        FILL_RANDOM,
        FILL_SMALL,
        FILL_EDGES,
        FILL_MAX,
        FILL_MIN
    } t_fill;

    typedef struct packed {
        logic signed [SUM_W-1:0]      sum;
        logic [msc_pkg::OUT_X_W-1:0]  x;
        logic [msc_pkg::OUT_Y_W-1:0]  y;
        logic [msc_pkg::OUT_Z_W-1:0]  z;
    } t_cube_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [msc_pkg::APB_ADDR_W-1:0] paddr;
    logic [msc_pkg::APB_DATA_W-1:0] pwdata;
    logic [msc_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    msc_in_if                   vox_if ();
    msc_out_if #(.SUM_W(SUM_W)) cube_if ();

    max_sum_cube_window_search i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (vox_if),
        .o_out   (cube_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // search state mirrored by the testbench
    logic [msc_pkg::DIM_X_W-1:0]  dim_x_q;
    logic [msc_pkg::DIM_YZ_W-1:0] dim_y_q;
    logic [msc_pkg::DIM_YZ_W-1:0] dim_z_q;
    int                           recent_vox [CUBE_TAIL];
    int                           row_sums [CUBE_TAIL][ROW_LEN_MAX];
    int                           plane_sums [CUBE_TAIL][ROWS_MAX][ROW_LEN_MAX];
    int unsigned                  at_x;
    int unsigned                  at_y;
    int unsigned                  at_z;
    int                           best_val;
    logic [msc_pkg::OUT_X_W-1:0]  best_cx;
    logic [msc_pkg::OUT_Y_W-1:0]  best_cy;
    logic [msc_pkg::OUT_Z_W-1:0]  best_cz;
    bit                           have_best;

    t_cube_result                 cube_expect_q [$];

    int unsigned                  errors;
    int unsigned                  items_sent;
    int unsigned                  cycle_count;
    int unsigned                  src_idle_pct;
    int unsigned                  snk_idle_pct;
    int unsigned                  hold_asked;
    int unsigned                  hold_granted;
    int unsigned                  hold_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    // zero counts as one, large values saturate
    function automatic int unsigned axis_len(int unsigned raw, int unsigned lim);
        if (raw == 0) begin
            return 1;
        end
        return (raw > lim) ? lim : raw;
    endfunction

    function automatic int unsigned volume_items();
        return axis_len(dim_x_q, msc_pkg::PLANE_LIMIT) * axis_len(dim_y_q, ROWS_MAX)
               * axis_len(dim_z_q, ROW_LEN_MAX);
    endfunction

    function automatic logic signed [msc_pkg::VOXEL_W-1:0] pick_voxel(t_fill fill);
        case (fill)
            FILL_SMALL: begin
                return msc_pkg::VOXEL_W'(int'($urandom_range(4)) - 2);
            end
            FILL_EDGES: begin
                case ($urandom_range(3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            FILL_MAX: begin
                return 16'sh7FFF;
            end
            FILL_MIN: begin
                return 16'sh8000;
            end
            default: begin
                return msc_pkg::VOXEL_W'($urandom);
            end
        endcase
    endfunction

    function automatic int unsigned pick_axis();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) begin
            return $urandom_range(2);
        end else if (r < 90) begin
            return $urandom_range(5, 3);
        end
        return $urandom_range(8, 6);
    endfunction

    task automatic restart_volume();
        at_x      = 0;
        at_y      = 0;
        at_z      = 0;
        have_best = 1'b0;
        best_val  = 0;
        best_cx   = '0;
        best_cy   = '0;
        best_cz   = '0;
    endtask

    // running window sums for one accepted voxel
    task automatic track_voxel(input logic signed [msc_pkg::VOXEL_W-1:0] v, input bit is_last);
        int unsigned  nx;
        int unsigned  ny;
        int unsigned  nz;
        int unsigned  x;
        int unsigned  y;
        int unsigned  z;
        int           row_acc;
        int           sq_acc;
        int           cube_acc;
        t_cube_result res;
        nx = axis_len(dim_x_q, msc_pkg::PLANE_LIMIT);
        ny = axis_len(dim_y_q, ROWS_MAX);
        nz = axis_len(dim_z_q, ROW_LEN_MAX);
        x  = at_x;
        y  = at_y % ROWS_MAX;
        z  = at_z % ROW_LEN_MAX;

        if (z >= CUBE_TAIL) begin
            row_acc = v;
            for (int i = 0; i < CUBE_TAIL; i++) row_acc += recent_vox[i];
            if (y >= CUBE_TAIL) begin
                sq_acc = row_acc;
                for (int i = 0; i < CUBE_TAIL; i++) sq_acc += row_sums[i][z];
                if (x >= CUBE_TAIL) begin
                    cube_acc = sq_acc;
                    for (int i = 0; i < CUBE_TAIL; i++) cube_acc += plane_sums[i][y][z];
                    // strict compare keeps the first corner on a tie
                    if (!have_best || cube_acc > best_val) begin
                        best_val  = cube_acc;
                        best_cx   = msc_pkg::OUT_X_W'(x - CUBE_TAIL);
                        best_cy   = msc_pkg::OUT_Y_W'(y - CUBE_TAIL);
                        best_cz   = msc_pkg::OUT_Z_W'(z - CUBE_TAIL);
                        have_best = 1'b1;
                    end
                end
                plane_sums[x % CUBE_TAIL][y][z] = sq_acc;
            end
            row_sums[y % CUBE_TAIL][z] = row_acc;
        end
        for (int i = CUBE_TAIL - 1; i > 0; i--) recent_vox[i] = recent_vox[i - 1];
        recent_vox[0] = v;

        if (is_last) begin
            res.sum = SUM_W'(best_val);
            res.x   = best_cx;
            res.y   = best_cy;
            res.z   = best_cz;
            cube_expect_q.push_back(res);
            restart_volume();
        end else begin
            at_z++;
            if (at_z >= nz) begin
                at_z = 0;
                at_y++;
                if (at_y >= ny) begin
                    at_y = 0;
                    at_x++;
                    if (at_x >= nx) begin
                        at_x = 0;
                    end
                end
            end
        end
    endtask

    task automatic track_reg_write(input logic [msc_pkg::REG_IDX_W-1:0] idx,
                                   input logic [31:0] data);
        if (idx == msc_pkg::REG_DIM_X) begin
            dim_x_q = data[msc_pkg::DIM_X_W-1:0];
        end else if (idx == msc_pkg::REG_DIM_Y) begin
            dim_y_q = data[msc_pkg::DIM_YZ_W-1:0];
        end else if (idx == msc_pkg::REG_DIM_Z) begin
            dim_z_q = data[msc_pkg::DIM_YZ_W-1:0];
        end else begin
            return;
        end
        restart_volume();
    endtask

    // a setup phase and an access phase on the register port
    task automatic reg_access(input logic [msc_pkg::REG_IDX_W-1:0] idx, input bit wr,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_write(input logic [msc_pkg::REG_IDX_W-1:0] idx, input logic [31:0] data);
        logic [31:0] unused;
        reg_access(idx, 1'b1, data, unused);
        track_reg_write(idx, data);
    endtask

    task automatic check_reg(input logic [msc_pkg::REG_IDX_W-1:0] idx);
        logic [31:0] got;
        reg_access(idx, 1'b0, '0, got);
        if (idx == msc_pkg::REG_DIM_X) begin
            check_field("dim_x readback", dim_x_q, got[msc_pkg::DIM_X_W-1:0]);
        end else if (idx == msc_pkg::REG_DIM_Y) begin
            check_field("dim_y readback", dim_y_q, got[msc_pkg::DIM_YZ_W-1:0]);
        end else begin
            check_field("dim_z readback", dim_z_q, got[msc_pkg::DIM_YZ_W-1:0]);
        end
    endtask

    // one voxel beat, with random gaps ahead of it
    task automatic send_voxel(input logic signed [msc_pkg::VOXEL_W-1:0] v, input bit is_last);
        while ($urandom_range(99) < src_idle_pct) begin
            vox_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        vox_if.valid      <= 1'b1;
        vox_if.voxel      <= v;
        vox_if.last_voxel <= is_last;
        do @(posedge i_clk); while (!vox_if.ready);
        track_voxel(v, is_last);
        items_sent++;
    endtask

    task automatic send_run(input int unsigned count, input bit mark_last, input t_fill fill);
        for (int unsigned i = 0; i < count; i++) begin
            send_voxel(pick_voxel(fill), mark_last && (i == count - 1));
        end
    endtask

    // stop the stream and let every result drain
    task automatic settle();
        vox_if.valid <= 1'b0;
        while (cube_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // upper data bits carry junk that the block must drop
    task automatic set_dims(input int unsigned nx, input int unsigned ny, input int unsigned nz);
        settle();
        reg_write(msc_pkg::REG_DIM_X, nx | ($urandom << msc_pkg::DIM_X_W));
        reg_write(msc_pkg::REG_DIM_Y, ny | ($urandom << msc_pkg::DIM_YZ_W));
        reg_write(msc_pkg::REG_DIM_Z, nz | ($urandom << msc_pkg::DIM_YZ_W));
    endtask

    task automatic test_register_access();
        check_reg(msc_pkg::REG_DIM_X);
        check_reg(msc_pkg::REG_DIM_Y);
        check_reg(msc_pkg::REG_DIM_Z);
        // default geometry, cut short before the first full cube
        send_run(40, 1'b1, FILL_RANDOM);
        set_dims(3, 3, 3);
        check_reg(msc_pkg::REG_DIM_X);
        check_reg(msc_pkg::REG_DIM_Y);
        check_reg(msc_pkg::REG_DIM_Z);
        // write to the unused index mid volume leaves the volume running
        send_run(13, 1'b0, FILL_RANDOM);
        settle();
        reg_write(REG_SPARE, $urandom);
        check_reg(msc_pkg::REG_DIM_X);
        check_reg(msc_pkg::REG_DIM_Y);
        check_reg(msc_pkg::REG_DIM_Z);
        send_run(14, 1'b1, FILL_RANDOM);
    endtask

    task automatic test_no_cube();
        set_dims(3, 3, 3);
        send_run(1, 1'b1, FILL_MAX);
        send_run(26, 1'b1, FILL_RANDOM);
        // one axis below the cube edge
        set_dims(2, 3, 3);
        send_run(volume_items(), 1'b1, FILL_MAX);
        set_dims(3, 2, 3);
        send_run(volume_items(), 1'b1, FILL_MAX);
        set_dims(3, 3, 2);
        send_run(volume_items(), 1'b1, FILL_MAX);
        // zero lengths count as one
        set_dims(0, 0, 0);
        send_run(5, 1'b1, FILL_MAX);
        // single plane that wraps
        set_dims(1, 3, 3);
        send_run(30, 1'b1, FILL_MAX);
    endtask

    task automatic test_value_extremes();
        set_dims(3, 3, 3);
        send_run(27, 1'b1, FILL_MAX);
        send_run(27, 1'b1, FILL_MIN);
        // every cube ties under the minimum fill, first corner wins; then edge values
        set_dims(4, 4, 4);
        send_run(64, 1'b1, FILL_MIN);
        send_run(64, 1'b1, FILL_EDGES);
    endtask

    task automatic test_volume_overrun();
        set_dims(3, 3, 4);
        send_run(36 * 2 + 20, 1'b1, FILL_RANDOM);
    endtask

    task automatic test_restart_on_write();
        set_dims(4, 3, 3);
        send_run(20, 1'b0, FILL_MAX);
        settle();
        reg_write(msc_pkg::REG_DIM_Z, 4);
        send_run(volume_items(), 1'b1, FILL_RANDOM);
    endtask

    task automatic test_dim_limits();
        // plane count saturates; the run ends long before the wrap
        set_dims(2047, 3, 3);
        check_reg(msc_pkg::REG_DIM_X);
        send_run(27, 1'b1, FILL_MAX);
        // row length saturates, the row wraps at the limit
        set_dims(3, 3, 127);
        check_reg(msc_pkg::REG_DIM_Z);
        send_run(70, 1'b1, FILL_RANDOM);
        // row count saturates, the plane wraps at the limit
        set_dims(3, 127, 3);
        check_reg(msc_pkg::REG_DIM_Y);
        send_run(200, 1'b1, FILL_RANDOM);
    endtask

    // mostly whole volumes, some cut short, some running past the end
    task automatic test_random_volumes(input int unsigned item_goal, input int unsigned vol_goal);
        int unsigned first_item;
        int unsigned vols;
        int unsigned count;
        int unsigned r;
        t_fill       fill;
        first_item = items_sent;
        vols       = 0;
        while (items_sent - first_item < item_goal || vols < vol_goal) begin
            if (vols == 0 || $urandom_range(2) == 0) begin
                set_dims(pick_axis(), pick_axis(), pick_axis());
            end
            count = volume_items();
            r     = $urandom_range(99);
            if (r < 12) begin
                count = $urandom_range(count, 1);
            end else if (r < 22) begin
                count += $urandom_range(count, 1);
            end
            r = $urandom_range(99);
            if (r < 60) begin
                fill = FILL_RANDOM;
            end else if (r < 80) begin
                fill = FILL_SMALL;
            end else begin
                fill = FILL_EDGES;
            end
            send_run(count, 1'b1, fill);
            vols++;
        end
    endtask

    // results pile up behind a long receiver stall
    task automatic test_backpressure();
        set_dims(3, 3, 3);
        hold_asked <= hold_asked + 1;
        repeat (5) send_run(27, 1'b1, FILL_RANDOM);
    endtask

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_asked != hold_granted) begin
            hold_granted <= hold_asked;
            hold_left    <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result beats: compare against the oldest expectation, then drive ready
    always @(posedge i_clk) begin
        t_cube_result want;
        if (cube_if.valid && cube_if.ready) begin
            if (cube_expect_q.size() == 0) begin
                $display("%0t: unexpected result beat, got sum %0d x %0d y %0d z %0d",
                         $time, $signed(cube_if.best_sum), cube_if.best_x, cube_if.best_y,
                         cube_if.best_z);
                errors++;
            end else begin
                want = cube_expect_q.pop_front();
                check_field("best_sum", int'(want.sum), int'($signed(cube_if.best_sum)));
                check_field("best_x", want.x, cube_if.best_x);
                check_field("best_y", want.y, cube_if.best_y);
                check_field("best_z", want.z, cube_if.best_z);
            end
        end
        cube_if.ready <= i_rst_n && (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        vox_if.valid      <= 1'b0;
        vox_if.voxel      <= '0;
        vox_if.last_voxel <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        dim_x_q           = msc_pkg::DIM_X_W'(msc_pkg::RESET_DIM_X);
        dim_y_q           = msc_pkg::DIM_YZ_W'(msc_pkg::RESET_DIM_Y);
        dim_z_q           = msc_pkg::DIM_YZ_W'(msc_pkg::RESET_DIM_Z);
        restart_volume();
        src_idle_pct      = 26;
        snk_idle_pct      = 60;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_no_cube();
        test_value_extremes();
        test_volume_overrun();
        test_restart_on_write();
        test_dim_limits();
        test_random_volumes(30, 2);

        src_idle_pct = 60;
        snk_idle_pct = 26;
        test_random_volumes(30, 2);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_volumes(30, 2);
        test_backpressure();

        settle();
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/msc_pkg.sv
rtl/msc_ifs.sv
rtl/msc_cfg.sv
rtl/msc_lane_ram.sv
rtl/msc_front.sv
rtl/msc_best.sv
rtl/max_sum_cube_window_search.sv
rtl/msc_checker.sv
verif/tb_top.sv
